FILE: sv/sha512_pkg.sv
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned Rounds = 80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned HashWords = 8;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT_RD,
    ST_OUT_HOLD
  } state_e;

  // Round constants of the compression function.
  function automatic word_t round_k(input logic [6:0] r);
    word_t k;
    case (r)
      7'd0: k = 64'h428a2f98d728ae22;   7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;   7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;   7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;   7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;   7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Initial hash values; mode 1 selects the shorter digest.
  function automatic word_t init_hash(input logic mode, input logic [2:0] idx);
    word_t h;
    case ({mode, idx})
      4'd0: h = 64'h6a09e667f3bcc908;  4'd1: h = 64'hbb67ae8584caa73b;
      4'd2: h = 64'h3c6ef372fe94f82b;  4'd3: h = 64'ha54ff53a5f1d36f1;
      4'd4: h = 64'h510e527fade682d1;  4'd5: h = 64'h9b05688c2b3e6c1f;
      4'd6: h = 64'h1f83d9abfb41bd6b;  4'd7: h = 64'h5be0cd19137e2179;
      4'd8: h = 64'hcbbb9d5dc1059ed8;  4'd9: h = 64'h629a292a367cd507;
      4'd10: h = 64'h9159015a3070dd17; 4'd11: h = 64'h152fecd8f70e5939;
      4'd12: h = 64'h67332667ffc00b31; 4'd13: h = 64'h8eb44a8768581511;
      4'd14: h = 64'hdb0c2e0d64f98fa7; 4'd15: h = 64'h47b5481dbefa4fa4;
      default: h = '0;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

FILE: sv/sha512_sha384_hash_core.sv
// SHA-512 / SHA-384 hash core. Message words enter on the slave stream, 64 bits
// each with the first byte on top; tlast closes the message and the word then
// carries 0 to 8 valid bytes. Each 16-word block is collected from the input,
// the working variables are loaded from the hash memory, 80 rounds run (one
// round per cycle) and the result is folded back into the hash memory. At the
// end of a message the padding is generated at one word per cycle and
// compressed in one or two blocks, then the digest leaves as 8 words (SHA-512)
// or 6 (SHA-384), each read from the hash memory and held until taken, tlast on
// the final one. digest_mode is sampled at the first word of each message. No
// request is taken while a block is compressed or the digest is sent.
module sha512_sha384_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_wdata_i,     // digest_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // msg_word[63:0], valid_bytes[67:64], zeros
  input  logic        s_axis_tlast_i,  // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // digest_word[63:0]
  output logic        m_axis_tlast_o   // last_of_digest
);
  import sha512_pkg::*;

  state_e state_q, state_d;
  logic [3:0] cnt_q;
  logic [6:0] round_q;
  logic [3:0] wib_q;
  logic [63:0] bytes_q;
  word_t win_q [BlockWords];
  word_t v_q [HashWords];
  logic mode_q, mode_lat_q, busy_q, first_blk_q;
  logic pad_q, mark_q, z14_q, done_q;
  logic [2:0] oidx_q;

  // Hash memory: one write and one registered read per cycle.
  word_t hmem [HashWords];
  word_t rdata_q;
  logic [2:0] raddr, waddr;
  logic hwe;
  word_t hwdata;

  logic in_req, out_req, push_en, cnt_end, last_out;
  word_t push_data, src, in_word, w_new, t1, t2;
  logic [2:0] didx;
  logic [3:0] vbc;
  logic [6:0] sh;

  assign in_req  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_req = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign m_axis_tvalid_o = (state_q == ST_OUT_HOLD);
  assign m_axis_tdata_o  = rdata_q;
  assign last_out = mode_lat_q ? (oidx_q == 3'd5) : (oidx_q == 3'd7);
  assign m_axis_tlast_o  = last_out;

  // Last word: keep the valid bytes and place the 0x80 marker under them.
  assign vbc = (s_axis_tdata_i[67:64] > 4'd8) ? 4'd8 : s_axis_tdata_i[67:64];
  assign sh  = {vbc, 3'b000};
  assign in_word = s_axis_tlast_i
      ? ((s_axis_tdata_i[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF >> sh))
         | (64'h8000_0000_0000_0000 >> sh))
      : s_axis_tdata_i[63:0];

  // Word pushed into the block window, from the input or the padding logic.
  always_comb begin
    push_en = 1'b0;
    push_data = '0;
    if (state_q == ST_COLLECT && in_req) begin
      push_en = 1'b1;
      push_data = in_word;
    end else if (state_q == ST_PAD) begin
      push_en = 1'b1;
      if (mark_q) begin
        push_data = 64'h8000_0000_0000_0000;
      end else if (wib_q == 4'd15 && z14_q) begin
        push_data = {bytes_q[60:0], 3'b000};
      end
    end
  end

  // Load and fold sweep: the read address leads the data index by one to cover the registered read.
  assign cnt_end = (cnt_q == 4'd8);
  assign didx = cnt_q[2:0] - 3'd1;
  assign src = first_blk_q ? init_hash(mode_lat_q, didx) : rdata_q;
  assign raddr = (state_q == ST_LOAD || state_q == ST_FOLD) ? cnt_q[2:0] : oidx_q;
  assign hwe = (state_q == ST_FOLD) && (cnt_q != 4'd0);
  assign waddr = didx;
  assign hwdata = src + v_q[0];

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hmem[waddr] <= hwdata;
    end
    rdata_q <= hmem[raddr];
  end

  // Round function and message schedule expansion.
  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(round_q) + win_q[0];
    t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = (rotr(win_q[14], 19) ^ rotr(win_q[14], 61) ^ (win_q[14] >> 6))
          + win_q[9]
          + (rotr(win_q[1], 1) ^ rotr(win_q[1], 8) ^ (win_q[1] >> 7))
          + win_q[0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_req) begin
          if (wib_q == 4'd15) begin
            state_d = ST_LOAD;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wib_q == 4'd15) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_end) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_q == 7'(Rounds - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cnt_end) begin
          if (done_q) begin
            state_d = ST_OUT_RD;
          end else if (pad_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_COLLECT;
          end
        end
      end
      ST_OUT_RD: state_d = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_req) begin
          state_d = last_out ? ST_COLLECT : ST_OUT_RD;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      round_q <= '0;
      wib_q <= '0;
      bytes_q <= '0;
      mode_q <= 1'b0;
      mode_lat_q <= 1'b0;
      busy_q <= 1'b0;
      first_blk_q <= 1'b0;
      pad_q <= 1'b0;
      mark_q <= 1'b0;
      z14_q <= 1'b0;
      done_q <= 1'b0;
      oidx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i[0];
      end
      if (push_en) begin
        wib_q <= wib_q + 4'd1;
      end
      // Message start and byte count.
      if (in_req) begin
        if (!busy_q) begin
          busy_q <= 1'b1;
          mode_lat_q <= mode_q;
          first_blk_q <= 1'b1;
        end
        if (s_axis_tlast_i) begin
          bytes_q <= (busy_q ? bytes_q : 64'd0) + {60'd0, vbc};
          pad_q <= 1'b1;
          mark_q <= (vbc == 4'd8);
          z14_q <= 1'b0;
          done_q <= 1'b0;
        end else begin
          bytes_q <= (busy_q ? bytes_q : 64'd0) + 64'd8;
        end
      end
      // Padding progress.
      if (state_q == ST_PAD) begin
        if (mark_q) begin
          mark_q <= 1'b0;
          z14_q <= 1'b0;
        end else if (wib_q == 4'd15 && z14_q) begin
          done_q <= 1'b1;
          z14_q <= 1'b0;
        end else begin
          z14_q <= (wib_q == 4'd14);
        end
      end
      if (state_q == ST_LOAD || state_q == ST_FOLD) begin
        cnt_q <= cnt_end ? 4'd0 : cnt_q + 4'd1;
      end
      if (state_q == ST_FOLD && cnt_end) begin
        first_blk_q <= 1'b0;
        oidx_q <= '0;
      end
      if (state_q == ST_ROUND) begin
        round_q <= (round_q == 7'(Rounds - 1)) ? 7'd0 : round_q + 7'd1;
      end
      if (state_q == ST_OUT_HOLD && out_req) begin
        oidx_q <= oidx_q + 3'd1;
        if (last_out) begin
          busy_q <= 1'b0;
          pad_q <= 1'b0;
          done_q <= 1'b0;
        end
      end
    end
  end

  // Block window and working variables.
  always_ff @(posedge clk_i) begin
    if (push_en || state_q == ST_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BlockWords-1] <= push_en ? push_data : w_new;
    end
    if (state_q == ST_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if ((state_q == ST_LOAD || state_q == ST_FOLD) && cnt_q != 4'd0) begin
      for (int i = 0; i < HashWords - 1; i++) begin
        v_q[i] <= v_q[i+1];
      end
      v_q[HashWords-1] <= (state_q == ST_LOAD) ? src : v_q[0];
    end
  end

  // Input and output never open at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input and output open together");

  // The round counter stays inside the round range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (round_q < 7'(Rounds)))
    else $error("round counter out of range");

  // The digest ends on the word that matches the latched mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      ((mode_lat_q && oidx_q == 3'd5) || (!mode_lat_q && oidx_q == 3'd7)))
    else $error("digest length mismatch");

  // The length word only enters at the last slot of a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD && !mark_q && z14_q) |-> (wib_q == 4'd15))
    else $error("length word misplaced");

endmodule
